>>> rtl/smrp_pkg.sv
// ---------------------------------------------------------------------------
// smrp_pkg
// Types, codes and shared arithmetic for the servo mode record/playback unit.
// ---------------------------------------------------------------------------
`default_nettype none

package smrp_pkg;

  // Joystick sample range: full scale is 2^SampleBits - 1
  localparam int unsigned SampleBits = 12;
  localparam int unsigned SAMPLE_MAX = (1 << SampleBits) - 1;

  localparam int unsigned LevelW = 15;
  localparam int unsigned DelayW = 6;

  // Mode codes
  localparam logic [1:0] MODE_MANUAL  = 2'd0;
  localparam logic [1:0] MODE_SWEEP   = 2'd1;
  localparam logic [1:0] MODE_RECPLAY = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LO_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HI_WIDTH = 2'd1;
  localparam logic [1:0] CFG_STRIDE   = 2'd2;

  // What the result stage does with the held pulse
  localparam logic [1:0] HOLD_KEEP = 2'd0;
  localparam logic [1:0] HOLD_MAP  = 2'd1;
  localparam logic [1:0] HOLD_SET  = 2'd2;

  // Tick delays in ms
  localparam logic [DelayW-1:0] DELAY_BUTTON = 6'd0;
  localparam logic [DelayW-1:0] DELAY_MANUAL = 6'd20;
  localparam logic [DelayW-1:0] DELAY_RECORD = 6'd30;
  localparam logic [DelayW-1:0] DELAY_LAST   = 6'd60;
  localparam logic [DelayW-1:0] DELAY_SWEEP_TOP = 6'd30;

  localparam logic [LevelW-1:0] LO_WIDTH_RST = 15'd500;
  localparam logic [LevelW-1:0] HI_WIDTH_RST = 15'd2500;
  localparam logic [7:0]        STRIDE_RST   = 8'd10;
  localparam logic [LevelW-1:0] LEVEL_TOP    = 15'h7FFF;

  typedef struct packed {
    logic                  func;
    logic [SampleBits-1:0] joystick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        reg_idx;
    logic [LevelW-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic [1:0] mode_now;
    logic       recording_now;
  } status_t;

  typedef struct packed {
    logic [LevelW-1:0] servo_level;
    logic [DelayW-1:0] delay_ms;
    logic              led_red;
    logic              led_green;
    logic              led_blue;
    logic [1:0]        mode_now;
    logic              recording_now;
  } out_item_t;

  // Floor of a / (2^12 - 1) for a below 2^27: the shift series underestimates
  // by at most one, so a single remainder check fixes it.
  function automatic logic [LevelW-1:0] div_sample_max(input logic [26:0] a);
    logic [27:0] acc;
    logic [15:0] q0;
    logic [27:0] rem;
    acc = {1'b0, a} + 28'(a >> SampleBits) + 28'(a >> (2 * SampleBits));
    q0  = acc[27:12];
    rem = {1'b0, a} - {q0, 12'd0} + 28'(q0);
    if (rem >= 28'(SAMPLE_MAX)) begin
      q0 = q0 + 16'd1;
    end
    return q0[LevelW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/smrp_stream_if.sv
// ---------------------------------------------------------------------------
// smrp_stream_if
// Valid/ready channel with a typed payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface smrp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/servo_mode_record_playback_unit.sv
// ---------------------------------------------------------------------------
// servo_mode_record_playback_unit
// Servo pulse controller: manual, sweep and record/playback modes.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                  handshake
//  in_i     in   func, joystick                           valid/ready
//  out_o    out  servo_level, delay_ms, leds, mode, rec   valid/ready
//  cfg_i    in   reg_idx, wdata                           valid/ready
//
// One transaction per cycle while out_o is not stalled; a result passes the stage B,
// stage C and result registers after its input transaction before it is valid on out_o.
// Mode state, counters and the sample store update in the accept cycle; the
// sample map takes a multiply stage and a divide-by-full-scale stage.
// A stalled output fills the stages behind it before in_i.ready drops.
// Reset clears all control state; the sample store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_mode_record_playback_unit #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  smrp_stream_if.sink       in_i,
  smrp_stream_if.source     out_o,
  smrp_stream_if.sink       cfg_i
);

  localparam int unsigned PtrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SW   = smrp_pkg::SampleBits;
  localparam int unsigned LW   = smrp_pkg::LevelW;
  localparam int unsigned DW   = smrp_pkg::DelayW;

  // Configuration
  logic [LW-1:0] lo_width_q, hi_width_q;
  logic [7:0]    stride_q;

  // Mode state
  logic [1:0]      mode_q, mode_d;
  logic            recording_q, recording_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [LW-1:0]   sweep_level_q, sweep_level_d;
  logic            sweep_rising_q, sweep_rising_d;
  logic            red_q, red_d;
  logic [LW-1:0]   held_q, held_d;

  // Stage handshake
  logic in_ready, accept;
  logic ready_b, ready_c, move_b, move_c;

  // Accept-stage decode
  smrp_pkg::in_item_t in_item;
  logic [1:0]      hold_a;
  logic            from_store_a;
  logic            sweep_delay_a;
  logic [DW-1:0]   delay_a;
  smrp_pkg::status_t status_a;
  logic            wr_en, rd_en;
  logic [PtrW-1:0] rd_addr;
  logic [15:0]     sweep_sum;
  logic [LW-1:0]   sweep_lv;
  logic [CntW-1:0] ptr_next;

  // Sample store
  logic [SW-1:0] store_mem [STORE_DEPTH];
  logic [SW-1:0] rd_q;

  // Stage B
  logic            b_valid_q;
  logic [1:0]      b_hold_q;
  logic            b_from_store_q;
  logic            b_sweep_delay_q;
  logic [SW-1:0]   b_sample_q;
  logic [LW-1:0]   b_level_q;
  logic [DW-1:0]   b_delay_q;
  smrp_pkg::status_t b_status_q;
  logic [SW-1:0]   b_sample;
  logic [16:0]     b_scaled;
  logic [LW-1:0]   b_steps;
  logic [DW-1:0]   b_delay;

  // Stage C
  logic            c_valid_q;
  logic [1:0]      c_hold_q;
  logic [LW-1:0]   c_level_q;
  logic [DW-1:0]   c_delay_q;
  smrp_pkg::status_t c_status_q;
  logic [LW-1:0]   map_level;

  // Result
  logic                out_valid_q;
  smrp_pkg::out_item_t out_q;

  assign in_item = in_i.data;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_width_q <= smrp_pkg::LO_WIDTH_RST;
      hi_width_q <= smrp_pkg::HI_WIDTH_RST;
      stride_q   <= smrp_pkg::STRIDE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_idx)
        smrp_pkg::CFG_LO_WIDTH: lo_width_q <= cfg_i.data.wdata;
        smrp_pkg::CFG_HI_WIDTH: hi_width_q <= cfg_i.data.wdata;
        smrp_pkg::CFG_STRIDE:   stride_q   <= cfg_i.data.wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage flow
  // ---------------------------------------------------------------------
  assign ready_c  = !out_valid_q || out_o.ready;
  assign move_c   = c_valid_q && ready_c;
  assign ready_b  = !c_valid_q || ready_c;
  assign move_b   = b_valid_q && ready_b;
  assign in_ready = !b_valid_q || ready_b;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // ---------------------------------------------------------------------
  // Accept stage: mode state and store access
  // ---------------------------------------------------------------------
  assign sweep_sum = {1'b0, sweep_level_q} + 16'(stride_q);

  always_comb begin
    if (sweep_rising_q) begin
      sweep_lv = sweep_sum[15] ? smrp_pkg::LEVEL_TOP : sweep_sum[LW-1:0];
    end else if (sweep_level_q < LW'(stride_q)) begin
      sweep_lv = '0;
    end else begin
      sweep_lv = sweep_level_q - LW'(stride_q);
    end
  end

  always_comb begin
    mode_d         = mode_q;
    recording_d    = recording_q;
    count_d        = count_q;
    ptr_d          = ptr_q;
    sweep_level_d  = sweep_level_q;
    sweep_rising_d = sweep_rising_q;
    red_d          = red_q;
    hold_a         = smrp_pkg::HOLD_KEEP;
    from_store_a   = 1'b0;
    sweep_delay_a  = 1'b0;
    delay_a        = smrp_pkg::DELAY_BUTTON;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = ptr_q;
    ptr_next       = '0;

    if (in_item.func) begin
      case (mode_q)
        smrp_pkg::MODE_MANUAL:  mode_d = smrp_pkg::MODE_SWEEP;
        smrp_pkg::MODE_SWEEP:   mode_d = smrp_pkg::MODE_RECPLAY;
        smrp_pkg::MODE_RECPLAY: mode_d = smrp_pkg::MODE_MANUAL;
        default:                mode_d = smrp_pkg::MODE_SWEEP;
      endcase
      if (mode_d == smrp_pkg::MODE_RECPLAY) begin
        count_d     = '0;
        ptr_d       = '0;
        recording_d = 1'b1;
      end else begin
        recording_d = 1'b0;
      end
    end else begin
      case (mode_q)
        smrp_pkg::MODE_SWEEP: begin
          sweep_level_d = sweep_lv;
          if (sweep_lv >= hi_width_q || sweep_lv <= lo_width_q) begin
            sweep_rising_d = !sweep_rising_q;
          end
          hold_a        = smrp_pkg::HOLD_SET;
          red_d         = 1'b0;
          sweep_delay_a = 1'b1;
        end
        smrp_pkg::MODE_RECPLAY: begin
          delay_a = smrp_pkg::DELAY_RECORD;
          if (recording_q) begin
            if (count_q < CntW'(STORE_DEPTH)) begin
              red_d   = !red_q;
              wr_en   = 1'b1;
              hold_a  = smrp_pkg::HOLD_MAP;
              count_d = count_q + CntW'(1);
            end else begin
              recording_d = 1'b0;
              red_d       = 1'b1;
            end
          end else begin
            red_d = 1'b1;
            if (count_q != '0) begin
              // Restart a pointer that ran past the recorded length
              if (CntW'(ptr_q) >= count_q) begin
                rd_addr = '0;
              end
              rd_en        = 1'b1;
              hold_a       = smrp_pkg::HOLD_MAP;
              from_store_a = 1'b1;
              ptr_next     = CntW'(rd_addr) + CntW'(1);
              if (ptr_next >= count_q) begin
                delay_a = smrp_pkg::DELAY_LAST;
                ptr_d   = '0;
              end else begin
                ptr_d = ptr_next[PtrW-1:0];
              end
            end
          end
        end
        default: begin
          hold_a  = smrp_pkg::HOLD_MAP;
          red_d   = 1'b0;
          delay_a = smrp_pkg::DELAY_MANUAL;
        end
      endcase
    end

    status_a.led_red       = red_d;
    status_a.led_green     = (mode_d == smrp_pkg::MODE_SWEEP);
    status_a.led_blue      = (mode_d inside {smrp_pkg::MODE_MANUAL, smrp_pkg::MODE_SPARE});
    status_a.mode_now      = mode_d;
    status_a.recording_now = recording_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= smrp_pkg::MODE_MANUAL;
      recording_q    <= 1'b0;
      count_q        <= '0;
      ptr_q          <= '0;
      sweep_level_q  <= smrp_pkg::LO_WIDTH_RST;
      sweep_rising_q <= 1'b1;
      red_q          <= 1'b0;
    end else if (accept) begin
      mode_q         <= mode_d;
      recording_q    <= recording_d;
      count_q        <= count_d;
      ptr_q          <= ptr_d;
      sweep_level_q  <= sweep_level_d;
      sweep_rising_q <= sweep_rising_d;
      red_q          <= red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      store_mem[count_q[PtrW-1:0]] <= in_item.joystick;
    end
    if (accept && rd_en) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: map multiply, sweep delay
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (accept) begin
      b_valid_q <= 1'b1;
    end else if (move_b) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_hold_q        <= hold_a;
      b_from_store_q  <= from_store_a;
      b_sweep_delay_q <= sweep_delay_a;
      b_sample_q      <= in_item.joystick;
      b_level_q       <= sweep_lv;
      b_delay_q       <= delay_a;
      b_status_q      <= status_a;
    end
  end

  assign b_sample = b_from_store_q ? rd_q : b_sample_q;

  // 29 * sample, then floor-divide by full scale
  assign b_scaled = ({5'd0, b_sample_q} << 5) - ({5'd0, b_sample_q} << 1)
                    - {5'd0, b_sample_q};
  assign b_steps  = smrp_pkg::div_sample_max({10'd0, b_scaled});
  assign b_delay  = b_sweep_delay_q ? (smrp_pkg::DELAY_SWEEP_TOP - b_steps[DW-1:0])
                                    : b_delay_q;

  smrp_map u_map (
    .clk_i      (clk_i),
    .load_i     (move_b),
    .sample_i   (b_sample),
    .lo_width_i (lo_width_q),
    .hi_width_i (hi_width_q),
    .level_o    (map_level)
  );

  // ---------------------------------------------------------------------
  // Stage C: divide, update held pulse
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (move_b) begin
      c_valid_q <= 1'b1;
    end else if (move_c) begin
      c_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_b) begin
      c_hold_q   <= b_hold_q;
      c_level_q  <= b_level_q;
      c_delay_q  <= b_delay;
      c_status_q <= b_status_q;
    end
  end

  always_comb begin
    case (c_hold_q)
      smrp_pkg::HOLD_MAP: held_d = map_level;
      smrp_pkg::HOLD_SET: held_d = c_level_q;
      default:            held_d = held_q;
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (move_c) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_c) begin
      out_q.servo_level   <= held_d;
      out_q.delay_ms      <= c_delay_q;
      out_q.led_red       <= c_status_q.led_red;
      out_q.led_green     <= c_status_q.led_green;
      out_q.led_blue      <= c_status_q.led_blue;
      out_q.mode_now      <= c_status_q.mode_now;
      out_q.recording_now <= c_status_q.recording_now;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

>>> rtl/smrp_map.sv
// ---------------------------------------------------------------------------
// smrp_map
// Two-stage linear map of a joystick sample onto the configured pulse range.
// ---------------------------------------------------------------------------
`default_nettype none

module smrp_map (
  input  wire logic                                clk_i,
  input  wire logic                                load_i,
  input  wire logic [smrp_pkg::SampleBits-1:0]     sample_i,
  input  wire logic [smrp_pkg::LevelW-1:0]         lo_width_i,
  input  wire logic [smrp_pkg::LevelW-1:0]         hi_width_i,
  output      logic [smrp_pkg::LevelW-1:0]         level_o
);

  logic signed [15:0] span;
  logic signed [28:0] product_full;
  logic signed [27:0] product_d;
  logic signed [27:0] product_q;
  logic               neg;
  logic        [27:0] mag;
  logic [smrp_pkg::LevelW-1:0] quot;
  logic signed [17:0] sq;
  logic signed [17:0] lvl;

  assign span         = $signed({1'b0, hi_width_i}) - $signed({1'b0, lo_width_i});
  assign product_full = $signed({1'b0, sample_i}) * span;
  assign product_d    = product_full[27:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      product_q <= product_d;
    end
  end

  // Truncate toward zero: divide the magnitude, then restore the sign
  assign neg  = product_q[27];
  assign mag  = neg ? 28'(-product_q) : 28'(product_q);
  assign quot = smrp_pkg::div_sample_max(mag[26:0]);
  assign sq   = neg ? -$signed({3'b000, quot}) : $signed({3'b000, quot});
  assign lvl  = sq + $signed({3'b000, lo_width_i});

  always_comb begin
    if (lvl < 18'sd0) begin
      level_o = '0;
    end else if (lvl > $signed({3'b000, smrp_pkg::LEVEL_TOP})) begin
      level_o = smrp_pkg::LEVEL_TOP;
    end else begin
      level_o = lvl[smrp_pkg::LevelW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> tb/servo_mode_record_playback_unit_test.sv
// ---------------------------------------------------------------------------
// servo_mode_record_playback_unit_test
// Self-checking bench for the servo mode record/playback unit. A shadow model
// tracks mode, sweep, record store and playback state. It predicts one status
// per accepted command, and each status leaving the unit is checked against
// the oldest prediction. Directed register extremes come first, then a full
// record/playback run with wrap, then short random mode sessions.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_mode_record_playback_unit_test;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned ItemTarget = 550;
  localparam int unsigned PulseTop   = 19999;
  localparam int unsigned SampleW    = smrp_pkg::SampleBits;
  localparam int unsigned LevelW     = smrp_pkg::LevelW;
  localparam logic [1:0]  CFG_SPARE  = 2'd3;

  class servo_shadow;
    logic [LevelW-1:0]     lo_width;
    logic [LevelW-1:0]     hi_width;
    logic [7:0]            stride;
    logic [1:0]            mode;
    bit                    recording;
    int unsigned           record_count;
    int unsigned           play_pointer;
    logic [SampleW-1:0]    samples [StoreDepth];
    int                    sweep_level;
    bit                    sweep_rising;
    int unsigned           held_level;
    bit                    red_state;
    smrp_pkg::out_item_t   expected_status [$];
    int unsigned           mismatches;

    function new();
      lo_width     = smrp_pkg::LO_WIDTH_RST;
      hi_width     = smrp_pkg::HI_WIDTH_RST;
      stride       = smrp_pkg::STRIDE_RST;
      mode         = smrp_pkg::MODE_MANUAL;
      recording    = 1'b0;
      record_count = 0;
      play_pointer = 0;
      sweep_level  = smrp_pkg::LO_WIDTH_RST;
      sweep_rising = 1'b1;
      held_level   = 0;
      red_state    = 1'b0;
      mismatches   = 0;
    endfunction

    function void apply_config(logic [1:0] idx, logic [LevelW-1:0] wdata);
      case (idx)
        smrp_pkg::CFG_LO_WIDTH: lo_width = wdata;
        smrp_pkg::CFG_HI_WIDTH: hi_width = wdata;
        smrp_pkg::CFG_STRIDE:   stride   = wdata[7:0];
        default: ;
      endcase
    endfunction

    // Linear map onto the configured pulse range, truncating toward zero
    function int unsigned pulse_of(logic [SampleW-1:0] s);
      longint lo;
      longint span;
      longint full;
      longint r;
      lo   = lo_width;
      span = hi_width;
      span = span - lo;
      full = smrp_pkg::SAMPLE_MAX;
      r    = s;
      r    = (r * span) / full + lo;
      if (r < 0) r = 0;
      if (r > 32767) r = 32767;
      return int'(r);
    endfunction

    function void note_input(smrp_pkg::in_item_t it);
      smrp_pkg::out_item_t res;
      int          lv;
      int          step;
      int          lo;
      int          hi;
      int unsigned dly;
      int unsigned n;
      dly = smrp_pkg::DELAY_BUTTON;
      if (it.func) begin
        case (mode)
          smrp_pkg::MODE_MANUAL:  mode = smrp_pkg::MODE_SWEEP;
          smrp_pkg::MODE_SWEEP:   mode = smrp_pkg::MODE_RECPLAY;
          smrp_pkg::MODE_RECPLAY: mode = smrp_pkg::MODE_MANUAL;
          default:                mode = smrp_pkg::MODE_SWEEP;
        endcase
        if (mode == smrp_pkg::MODE_RECPLAY) begin
          record_count = 0;
          play_pointer = 0;
          recording    = 1'b1;
        end else begin
          recording = 1'b0;
        end
      end else begin
        case (mode)
          smrp_pkg::MODE_SWEEP: begin
            step = stride;
            lo   = lo_width;
            hi   = hi_width;
            lv   = sweep_rising ? sweep_level + step : sweep_level - step;
            if (lv < 0) lv = 0;
            if (lv > 32767) lv = 32767;
            sweep_level = lv;
            if (lv >= hi || lv <= lo) sweep_rising = !sweep_rising;
            held_level = lv;
            red_state  = 1'b0;
            dly = smrp_pkg::DELAY_SWEEP_TOP - (29 * it.joystick) / smrp_pkg::SAMPLE_MAX;
          end
          smrp_pkg::MODE_RECPLAY: begin
            dly = smrp_pkg::DELAY_RECORD;
            if (recording) begin
              red_state = !red_state;
              if (record_count < StoreDepth) begin
                samples[record_count] = it.joystick;
                held_level = pulse_of(it.joystick);
                record_count++;
              end else begin
                recording = 1'b0;
                red_state = 1'b1;
              end
            end else begin
              red_state = 1'b1;
              if (record_count > 0) begin
                n = (record_count > StoreDepth) ? StoreDepth : record_count;
                if (play_pointer >= n) play_pointer = 0;
                held_level = pulse_of(samples[play_pointer]);
                if (play_pointer + 1 >= n) begin
                  dly = smrp_pkg::DELAY_LAST;
                  play_pointer = 0;
                end else begin
                  play_pointer++;
                end
              end
            end
          end
          default: begin
            held_level = pulse_of(it.joystick);
            red_state  = 1'b0;
            dly = smrp_pkg::DELAY_MANUAL;
          end
        endcase
      end
      res.servo_level   = held_level[LevelW-1:0];
      res.delay_ms      = dly[smrp_pkg::DelayW-1:0];
      res.led_red       = red_state;
      res.led_green     = (mode == smrp_pkg::MODE_SWEEP);
      res.led_blue      = (mode == smrp_pkg::MODE_MANUAL) || (mode == smrp_pkg::MODE_SPARE);
      res.mode_now      = mode;
      res.recording_now = recording;
      expected_status.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(smrp_pkg::out_item_t got);
      smrp_pkg::out_item_t want;
      if (expected_status.size() == 0) begin
        $error("status with no command outstanding: %p", got);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("servo_level", 16'(want.servo_level), 16'(got.servo_level));
      compare_field("delay_ms", 16'(want.delay_ms), 16'(got.delay_ms));
      compare_field("led_red", 16'(want.led_red), 16'(got.led_red));
      compare_field("led_green", 16'(want.led_green), 16'(got.led_green));
      compare_field("led_blue", 16'(want.led_blue), 16'(got.led_blue));
      compare_field("mode_now", 16'(want.mode_now), 16'(got.mode_now));
      compare_field("recording_now", 16'(want.recording_now), 16'(got.recording_now));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  smrp_stream_if #(.payload_t(smrp_pkg::in_item_t))  in_ch ();
  smrp_stream_if #(.payload_t(smrp_pkg::out_item_t)) out_ch ();
  smrp_stream_if #(.payload_t(smrp_pkg::cfg_item_t)) cfg_ch ();

  servo_mode_record_playback_unit #(
    .STORE_DEPTH(StoreDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  servo_shadow shadow = new();
  bit          steady = 1'b0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones; none while steady
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SampleW'($urandom_range(smrp_pkg::SAMPLE_MAX));
    endcase
  endfunction

  function automatic int unsigned pick_pulse();
    case ($urandom_range(4))
      0:       return 0;
      1:       return PulseTop;
      2:       return $urandom_range(PulseTop);
      default: return $urandom_range(2600, 300);
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(3))
      0:       return 1;
      1:       return 255;
      default: return $urandom_range(255, 1);
    endcase
  endfunction

  // Hold valid across back-to-back transactions; lower it only for a gap
  task automatic send_item(input logic func, input logic [SampleW-1:0] joy);
    smrp_pkg::in_item_t it;
    int unsigned        gap;
    it.func     = func;
    it.joystick = joy;
    gap = pick_gap();
    if ($urandom_range(99) < 3) steady = !steady;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    shadow.note_input(it);
    sent++;
  endtask

  task automatic tick(input logic [SampleW-1:0] joy);
    send_item(1'b0, joy);
  endtask

  task automatic press();
    send_item(1'b1, SampleW'($urandom_range(smrp_pkg::SAMPLE_MAX)));
  endtask

  // Drain every outstanding status, then let the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (shadow.expected_status.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int unsigned val);
    smrp_pkg::cfg_item_t c;
    c.reg_idx = idx;
    c.wdata   = val[LevelW-1:0];
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk_i); while (!cfg_ch.ready);
    shadow.apply_config(idx, c.wdata);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input int unsigned lo, input int unsigned hi,
                              input int unsigned step);
    settle();
    write_cfg(smrp_pkg::CFG_LO_WIDTH, lo);
    write_cfg(smrp_pkg::CFG_HI_WIDTH, hi);
    write_cfg(smrp_pkg::CFG_STRIDE, step);
    // index past the register list must be ignored
    if ($urandom_range(3) == 0) write_cfg(CFG_SPARE, $urandom_range(PulseTop));
  endtask

  task automatic enter_mode(input logic [1:0] target);
    // record/playback is always entered fresh so the store is re-armed
    if (target == smrp_pkg::MODE_RECPLAY) begin
      do press(); while (shadow.mode != target);
    end else begin
      while (shadow.mode != target) press();
    end
  endtask

  // Result side: random stalls, drained every cycle ready is high
  initial begin
    int unsigned hold;
    bit          rdy;
    hold = 0;
    rdy  = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) shadow.check_result(out_ch.data);
      if (hold == 0) begin
        if (steady || $urandom_range(99) < 60) begin
          rdy  = 1'b1;
          hold = $urandom_range(8, 1);
        end else begin
          rdy  = 1'b0;
          hold = pick_gap() + 1;
        end
      end
      hold--;
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned len;
    logic [1:0]  kind;
    bit          wrapped;
    wrapped = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_ni       <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: every mode, sample extremes, leaving recording
    tick(12'd0);
    tick(12'hFFF);
    tick(12'h800);
    press();
    tick(12'd0);
    tick(12'hFFF);
    tick(12'h555);
    press();
    tick(12'hAAA);
    tick(12'hFFF);
    press();
    tick(12'd1);

    // Widest span, largest step
    program_regs(0, PulseTop, 255);
    write_cfg(CFG_SPARE, PulseTop);
    tick(12'd0);
    tick(12'hFFF);
    press();
    tick(12'd0);
    tick(12'hFFF);

    // Inverted span, smallest step: the sweep reverses every tick
    program_regs(PulseTop, 0, 1);
    tick(12'd0);
    tick(12'hFFF);
    press();
    tick(12'hFFF);
    tick(12'd0);
    press();
    tick(12'hFFF);
    tick(12'h7FF);

    program_regs(smrp_pkg::LO_WIDTH_RST, smrp_pkg::HI_WIDTH_RST, smrp_pkg::STRIDE_RST);

    while (sent < ItemTarget || !wrapped) begin
      r = $urandom_range(99);
      if (r < 20) begin
        program_regs(pick_pulse(), pick_pulse(), pick_step());
      end else if (r < 30) begin
        settle();
      end

      r = $urandom_range(99);
      if (!wrapped) kind = smrp_pkg::MODE_RECPLAY;
      else if (r < 30) kind = smrp_pkg::MODE_MANUAL;
      else if (r < 65) kind = smrp_pkg::MODE_SWEEP;
      else kind = smrp_pkg::MODE_RECPLAY;
      enter_mode(kind);

      case (kind)
        smrp_pkg::MODE_MANUAL: len = $urandom_range(12, 1);
        smrp_pkg::MODE_SWEEP:  len = $urandom_range(30, 1);
        default: begin
          if (!wrapped) begin
            // fill the store, stop recording, then play it through past the wrap
            len = StoreDepth + 1 + StoreDepth + $urandom_range(8, 2);
            wrapped = 1'b1;
          end else begin
            // cut the recording short with the next button press
            len = $urandom_range(20, 1);
          end
        end
      endcase
      repeat (len) tick(pick_sample());
    end

    settle();
    if (shadow.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/smrp_pkg.sv
rtl/smrp_stream_if.sv
rtl/smrp_map.sv
rtl/servo_mode_record_playback_unit.sv
tb/servo_mode_record_playback_unit_test.sv
